// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/trbo_pkg.sv =====
package trbo_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_TILE_WIDTH      = 3'd1,
        REG_TILE_HEIGHT     = 3'd2,
        REG_BYTES_PER_PIXEL = 3'd3,
        REG_BASE_OFFSET     = 3'd4,
        REG_CHUNK_ORIGIN_X  = 3'd5,
        REG_CHUNK_ORIGIN_Y  = 3'd6,
        REG_CHUNK_COLUMNS   = 3'd7
    } cfg_reg_t;

    localparam int CFG_DATA_W = 62;
    localparam int COORD_W    = 31;
    localparam int DIM_W      = 16;
    localparam int INDEX_W    = 32;
    // width of the full sum, one bit wider than it needs
    localparam int TOTAL_W    = 116;

    localparam logic [COORD_W-1:0] IMAGE_WIDTH_RST   = 31'd1;
    localparam logic [DIM_W-1:0]   TILE_WIDTH_RST    = 16'd256;
    localparam logic [DIM_W-1:0]   TILE_HEIGHT_RST   = 16'd256;
    localparam logic [DIM_W-1:0]   BPP_RST           = 16'd1;
    localparam logic [COORD_W-1:0] CHUNK_COLUMNS_RST = 31'd1;

endpackage

// ===== rtl/core/trbo_div_pipe.sv =====
module trbo_div_pipe #(
    parameter int NW    = 32,
    parameter int DW    = 16,
    parameter int LANES = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NW-1:0]   dividend,
    input  logic [LANES-1:0][DW-1:0]   divisor,
    output logic                       out_valid,
    output logic [LANES-1:0][NW-1:0]   quotient,
    output logic [LANES-1:0][DW-1:0]   remainder
);

    // one quotient bit per stage, restoring
    logic [NW-1:0]                 vld_reg;
    logic [LANES-1:0][NW-1:0]      n_reg  [NW];
    logic [LANES-1:0][DW-1:0]      r_reg  [NW];
    logic [LANES-1:0][NW-1:0]      n_next [NW];
    logic [LANES-1:0][DW-1:0]      r_next [NW];

    always_comb begin
        logic [DW:0]   t;
        logic [NW-1:0] n_in;
        logic [DW-1:0] r_in;
        for (int s = 0; s < NW; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    n_in = dividend[l];
                    r_in = '0;
                end else begin
                    n_in = n_reg[s-1][l];
                    r_in = r_reg[s-1][l];
                end
                t = {r_in, n_in[NW-1]};
                if (t >= {1'b0, divisor[l]}) begin
                    t              = t - {1'b0, divisor[l]};
                    n_next[s][l]   = {n_in[NW-2:0], 1'b1};
                end else begin
                    n_next[s][l]   = {n_in[NW-2:0], 1'b0};
                end
                r_next[s][l] = t[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int s = 0; s < NW; s++) begin
                n_reg[s] <= n_next[s];
                r_reg[s] <= r_next[s];
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quotient  = n_reg[NW-1];
    assign remainder = r_reg[NW-1];

endmodule

// ===== rtl/core/tiled_raster_byte_offset.sv =====
// path: chunk divider, raster register, tile divider, stages m1 to m6, output register
// throughput: one request per cycle, sustained; stalls on m_tready only
// the depth comes mostly from the two bit-serial divider pipelines (32 and 33 stages)
// aresetn (synchronous, active low) clears all valid bits and loads the
// register reset values; the data path holds no reset
`include "assert_macros.svh"

module tiled_raster_byte_offset import trbo_pkg::*; #(
    parameter int OFFSET_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [INDEX_W-1:0]    s_tdata,   // [31:0] pixel_index
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [OFFSET_BITS-2:0] byte_offset, [OFFSET_BITS-1] overflow, zero padded to bytes
    output logic [((OFFSET_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int TDATA_W = ((OFFSET_BITS+7)/8)*8;

    // ---------------- configuration registers ----------------
    logic [COORD_W-1:0] image_width_reg;
    logic [DIM_W-1:0]   tile_width_reg;
    logic [DIM_W-1:0]   tile_height_reg;
    logic [DIM_W-1:0]   bpp_reg;
    logic [61:0]        base_offset_reg;
    logic [COORD_W-1:0] origin_x_reg;
    logic [COORD_W-1:0] origin_y_reg;
    logic [COORD_W-1:0] chunk_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= IMAGE_WIDTH_RST;
            tile_width_reg  <= TILE_WIDTH_RST;
            tile_height_reg <= TILE_HEIGHT_RST;
            bpp_reg         <= BPP_RST;
            base_offset_reg <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            chunk_cols_reg  <= CHUNK_COLUMNS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:     image_width_reg <= cfg_wdata[COORD_W-1:0];
                REG_TILE_WIDTH:      tile_width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_TILE_HEIGHT:     tile_height_reg <= cfg_wdata[DIM_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg         <= cfg_wdata[DIM_W-1:0];
                REG_BASE_OFFSET:     base_offset_reg <= cfg_wdata[61:0];
                REG_CHUNK_ORIGIN_X:  origin_x_reg    <= cfg_wdata[COORD_W-1:0];
                REG_CHUNK_ORIGIN_Y:  origin_y_reg    <= cfg_wdata[COORD_W-1:0];
                REG_CHUNK_COLUMNS:   chunk_cols_reg  <= cfg_wdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // zero divisors behave as one
    logic [DIM_W-1:0]   tw_eff;
    logic [DIM_W-1:0]   th_eff;
    logic [COORD_W-1:0] cols_eff;
    assign tw_eff   = (tile_width_reg  == '0) ? DIM_W'(1)   : tile_width_reg;
    assign th_eff   = (tile_height_reg == '0) ? DIM_W'(1)   : tile_height_reg;
    assign cols_eff = (chunk_cols_reg  == '0) ? COORD_W'(1) : chunk_cols_reg;

    // derived sizes, registered from the configuration, settled long before any request needs them
    logic [31:0] tw_th_reg;
    logic [47:0] tile_bytes_reg;
    logic [31:0] row_bytes_reg;

    always_ff @(posedge aclk) begin
        tw_th_reg      <= tw_eff * th_eff;
        tile_bytes_reg <= tw_th_reg * bpp_reg;
        row_bytes_reg  <= tw_eff * bpp_reg;
    end

    // ---------------- pipeline control ----------------
    // the pipe moves whenever the output can take a result or the last stage is empty
    logic pipe_adv;
    logic m6_vld_reg;
    logic m_tvalid_reg;
    logic out_load;

    assign out_load = m_tready || !m_tvalid_reg;
    assign pipe_adv = out_load || !m6_vld_reg;
    assign s_tready = pipe_adv;

    // ---------------- chunk index to chunk row and column ----------------
    logic                       div_a_vld;
    logic [0:0][INDEX_W-1:0]    div_a_quo;
    logic [0:0][COORD_W-1:0]    div_a_rem;

    trbo_div_pipe #(
        .NW    (INDEX_W),
        .DW    (COORD_W),
        .LANES (1)
    ) u_div_chunk (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (pipe_adv),
        .in_valid  (s_tvalid),
        .dividend  (s_tdata),
        .divisor   (cols_eff),
        .out_valid (div_a_vld),
        .quotient  (div_a_quo),
        .remainder (div_a_rem)
    );

    // raster position
    logic        c_vld_reg;
    logic [31:0] rx_reg;
    logic [32:0] ry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (pipe_adv) begin
            c_vld_reg <= div_a_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            rx_reg <= {1'b0, origin_x_reg} + {1'b0, div_a_rem[0]};
            ry_reg <= {2'b0, origin_y_reg} + {1'b0, div_a_quo[0]};
        end
    end

    // ---------------- tile column, tile row and tiles per row ----------------
    // lane 0: x by tile width, lane 1: y by tile height, lane 2: image width by tile width
    logic                   div_b_vld;
    logic [2:0][32:0]       div_b_num;
    logic [2:0][DIM_W-1:0]  div_b_den;
    logic [2:0][32:0]       div_b_quo;
    logic [2:0][DIM_W-1:0]  div_b_rem;

    assign div_b_num[0] = {1'b0, rx_reg};
    assign div_b_num[1] = ry_reg;
    assign div_b_num[2] = {2'b0, image_width_reg};
    assign div_b_den[0] = tw_eff;
    assign div_b_den[1] = th_eff;
    assign div_b_den[2] = tw_eff;

    trbo_div_pipe #(
        .NW    (33),
        .DW    (DIM_W),
        .LANES (3)
    ) u_div_tile (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (pipe_adv),
        .in_valid  (c_vld_reg),
        .dividend  (div_b_num),
        .divisor   (div_b_den),
        .out_valid (div_b_vld),
        .quotient  (div_b_quo),
        .remainder (div_b_rem)
    );

    // ---------------- offset arithmetic ----------------
    logic        m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg, m5_vld_reg;
    // m1: tiles per row rounded up, in-tile byte terms
    logic [32:0] m1_tx_reg, m1_ty_reg;
    logic [31:0] m1_tile_cols_reg;
    logic [31:0] m1_in_x_b_reg;
    logic [47:0] m1_in_y_b_reg;
    // m2: tile row times tiles per row, base plus in-tile terms
    logic [64:0] m2_ti_prod_reg;
    logic [32:0] m2_tx_reg;
    logic [63:0] m2_small_reg;
    // m3: tile index
    logic [65:0] m3_tile_index_reg;
    logic [63:0] m3_small_reg;
    // m4: partial products of tile index times tile bytes
    logic [45:0] m4_pp_reg [3][2];
    logic [63:0] m4_small_reg;
    // m5, m6: reduction of the partial products
    logic [TOTAL_W-1:0] m5_lo_reg, m5_hi_reg;
    logic [63:0]        m5_small_reg;
    logic [TOTAL_W-1:0] m6_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
            m5_vld_reg <= 1'b0;
            m6_vld_reg <= 1'b0;
        end else if (pipe_adv) begin
            m1_vld_reg <= div_b_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
            m5_vld_reg <= m4_vld_reg;
            m6_vld_reg <= m5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            m1_tx_reg        <= div_b_quo[0];
            m1_ty_reg        <= div_b_quo[1];
            m1_tile_cols_reg <= div_b_quo[2][31:0] + {31'b0, |div_b_rem[2]};
            m1_in_x_b_reg    <= div_b_rem[0] * bpp_reg;
            m1_in_y_b_reg    <= div_b_rem[1] * row_bytes_reg;

            m2_ti_prod_reg   <= m1_ty_reg * m1_tile_cols_reg;
            m2_tx_reg        <= m1_tx_reg;
            m2_small_reg     <= {2'b0, base_offset_reg} + {32'b0, m1_in_x_b_reg}
                              + {16'b0, m1_in_y_b_reg};

            m3_tile_index_reg <= {1'b0, m2_ti_prod_reg} + {33'b0, m2_tx_reg};
            m3_small_reg      <= m2_small_reg;

            // tile index in 22-bit slices, tile bytes in 24-bit halves
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 2; j++) begin
                    m4_pp_reg[i][j] <= m3_tile_index_reg[22*i +: 22]
                                     * tile_bytes_reg[24*j +: 24];
                end
            end
            m4_small_reg <= m3_small_reg;

            m5_lo_reg <= TOTAL_W'(m4_pp_reg[0][0])
                       + (TOTAL_W'(m4_pp_reg[0][1]) << 24)
                       + (TOTAL_W'(m4_pp_reg[1][0]) << 22);
            m5_hi_reg <= (TOTAL_W'(m4_pp_reg[1][1]) << 46)
                       + (TOTAL_W'(m4_pp_reg[2][0]) << 44)
                       + (TOTAL_W'(m4_pp_reg[2][1]) << 68);
            m5_small_reg <= m4_small_reg;

            m6_total_reg <= m5_lo_reg + m5_hi_reg + TOTAL_W'(m5_small_reg);
        end
    end

    // ---------------- output register ----------------
    logic [TDATA_W-1:0] m_tdata_next;
    logic [TDATA_W-1:0] m_tdata_reg;

    always_comb begin
        m_tdata_next                    = '0;
        m_tdata_next[OFFSET_BITS-2:0]   = m6_total_reg[OFFSET_BITS-2:0];
        m_tdata_next[OFFSET_BITS-1]     = |m6_total_reg[TOTAL_W-1:OFFSET_BITS-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= m6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPLIES(a_chunk_rem_range, aclk, aresetn, div_a_vld, div_a_rem[0] < cols_eff, "chunk column remainder not below chunk columns")
    `ASSERT_IMPLIES(a_tile_rem_range, aclk, aresetn, div_b_vld, (div_b_rem[0] < tw_eff) && (div_b_rem[1] < th_eff), "in-tile position outside the tile")
    `ASSERT_NEXT(a_stall_holds_tail, aclk, aresetn, !pipe_adv, m6_vld_reg && $stable(m6_total_reg), "last stage changed during a stall")
    `ASSERT_NEXT(a_tail_reaches_out, aclk, aresetn, m6_vld_reg && out_load, m_tvalid, "finished result not presented")

endmodule
